// ===== sv/wh2h_pkg.sv =====
// Shared widths, codes and payload types of the weighted 2D histogram block.
package wh2h_pkg;

	localparam int IDX_W      = 4;
	localparam int AMP_W      = 16;
	localparam int SQ_W       = 31;
	localparam int WEIGHT_W   = 32;
	localparam int DENS_W     = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam int DEF_INDEX_BITS  = 4;
	localparam int DEF_ACC_BITS    = 48;
	localparam int DEF_QUEUE_DEPTH = 4;

	// item kinds
	localparam logic KIND_ACCUM = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_SURFACE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_INDEX_LIMIT = 2'd2;

	localparam logic [IDX_W-1:0] LIMIT_RESET = 4'hF;

	typedef struct packed {
		logic                    kind;
		logic                    surface;
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        second_index;
		logic signed [AMP_W-1:0] amp_real;
		logic signed [AMP_W-1:0] amp_imag;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  bin_first;
		logic [IDX_W-1:0]  bin_second;
		logic [DENS_W-1:0] density;
	} out_item_t;

	// queue entry: classified work for the back end
	typedef struct packed {
		logic                kind;
		logic [IDX_W-1:0]    bin_first;
		logic [IDX_W-1:0]    bin_second;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ===== sv/wh2h_in_if.sv =====
// Input channel: valid/ready with one histogram item.
interface wh2h_in_if;
	import wh2h_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/wh2h_out_if.sv =====
// Result channel: valid/ready with one bin read result.
interface wh2h_out_if;
	import wh2h_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/wh2h_front.sv =====
// Front end: config registers, item classification and weight squaring.
module wh2h_front #(
	parameter int INDEX_BITS = wh2h_pkg::DEF_INDEX_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wh2h_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wh2h_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wh2h_pkg::back_status_t             status,
	wh2h_in_if.sink                            item,
	output logic                               push_valid,
	input  logic                               push_ready,
	output wh2h_pkg::entry_t                   push_data
);
	import wh2h_pkg::*;

	logic             sel_surface_q;
	logic [IDX_W-1:0] first_limit_q;
	logic [IDX_W-1:0] second_limit_q;

	logic             v_s1;
	logic             kind_s1;
	logic [IDX_W-1:0] bf_s1;
	logic [IDX_W-1:0] bs_s1;
	logic [SQ_W-1:0]  sq_re_s1;
	logic [SQ_W-1:0]  sq_im_s1;

	logic                      accept;
	logic                      keep;
	logic [IDX_W-1:0]          fi_m;
	logic [IDX_W-1:0]          si_m;
	logic signed [2*AMP_W-1:0] p_re;
	logic signed [2*AMP_W-1:0] p_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_surface_q  <= 1'b0;
			first_limit_q  <= LIMIT_RESET;
			second_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SELECTED_SURFACE:   sel_surface_q  <= cfg_data[0];
				CFG_FIRST_INDEX_LIMIT:  first_limit_q  <= cfg_data[IDX_W-1:0];
				CFG_SECOND_INDEX_LIMIT: second_limit_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// indices masked to the bin grid
	assign fi_m = IDX_W'(INDEX_BITS'(item.data.first_index));
	assign si_m = IDX_W'(INDEX_BITS'(item.data.second_index));

	assign keep = (item.data.kind == KIND_READ) ||
	              ((item.data.surface == sel_surface_q) &&
	               (fi_m <= first_limit_q) && (si_m <= second_limit_q));

	assign item.ready = !status.clearing && (!v_s1 || push_ready);
	assign accept     = item.valid && item.ready;

	assign p_re = item.data.amp_real * item.data.amp_real;
	assign p_im = item.data.amp_imag * item.data.amp_imag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || push_ready) begin
			v_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= item.data.kind;
			bf_s1    <= fi_m;
			bs_s1    <= si_m;
			sq_re_s1 <= p_re[SQ_W-1:0];
			sq_im_s1 <= p_im[SQ_W-1:0];
		end
	end

	assign push_valid           = v_s1;
	assign push_data.kind       = kind_s1;
	assign push_data.bin_first  = bf_s1;
	assign push_data.bin_second = bs_s1;
	assign push_data.weight     = WEIGHT_W'(sq_re_s1) + WEIGHT_W'(sq_im_s1);

endmodule

// ===== sv/wh2h_fifo.sv =====
// Short register queue between front and back end.
module wh2h_fifo #(
	parameter int DEPTH = wh2h_pkg::DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  wh2h_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output wh2h_pkg::entry_t pop_data
);
	import wh2h_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	entry_t        entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/wh2h_back.sv =====
// Back end: bin memory read-modify-write, clearing pass and result register.
module wh2h_back #(
	parameter int INDEX_BITS = wh2h_pkg::DEF_INDEX_BITS,
	parameter int ACC_BITS   = wh2h_pkg::DEF_ACC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  wh2h_pkg::entry_t       pop_data,
	output wh2h_pkg::back_status_t status,
	wh2h_out_if.source             result
);
	import wh2h_pkg::*;

	localparam int AW   = 2 * INDEX_BITS;
	localparam int BINS = 1 << AW;

	logic [ACC_BITS-1:0] mem [BINS];
	logic [ACC_BITS-1:0] rd_q;

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic                v_s1;
	logic                kind_s1;
	logic [IDX_W-1:0]    bf_s1;
	logic [IDX_W-1:0]    bs_s1;
	logic [WEIGHT_W-1:0] w_s1;
	logic [AW-1:0]       addr_s1;
	logic                fwd_s1;
	logic [ACC_BITS-1:0] fwd_val_s1;

	logic      res_v_q;
	out_item_t res_q;

	logic [AW-1:0]       pop_addr;
	logic                s1_go;
	logic                s1_free;
	logic                do_pop;
	logic [ACC_BITS-1:0] old_val;
	logic [ACC_BITS:0]   sum;
	logic [ACC_BITS-1:0] acc_sat;
	logic [ACC_BITS-1:0] new_val;

	assign pop_addr = {INDEX_BITS'(pop_data.bin_first), INDEX_BITS'(pop_data.bin_second)};

	// a read stalls only on a full result register
	assign s1_go     = v_s1 && ((kind_s1 != KIND_READ) || !res_v_q || result.ready);
	assign s1_free   = !v_s1 || s1_go;
	assign pop_ready = s1_free && !clr_busy_q;
	assign do_pop    = pop_valid && pop_ready;

	assign old_val = fwd_s1 ? fwd_val_s1 : rd_q;
	assign sum     = (ACC_BITS+1)'(old_val) + (ACC_BITS+1)'(w_s1);
	assign acc_sat = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
	assign new_val = (kind_s1 == KIND_READ) ? '0 : acc_sat;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (s1_go) begin
			mem[addr_s1] <= new_val;
		end
		if (do_pop) begin
			rd_q <= mem[pop_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s1       <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (s1_free) begin
				v_s1 <= do_pop;
			end
			if (s1_go && (kind_s1 == KIND_READ)) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// the memory read misses a write to the same bin in the same cycle
	always_ff @(posedge clk) begin
		if (do_pop) begin
			kind_s1    <= pop_data.kind;
			bf_s1      <= pop_data.bin_first;
			bs_s1      <= pop_data.bin_second;
			w_s1       <= pop_data.weight;
			addr_s1    <= pop_addr;
			fwd_s1     <= v_s1 && (addr_s1 == pop_addr);
			fwd_val_s1 <= new_val;
		end
		if (s1_go && (kind_s1 == KIND_READ)) begin
			res_q.bin_first  <= bf_s1;
			res_q.bin_second <= bs_s1;
			res_q.density    <= DENS_W'(old_val);
		end
	end

	assign status.clearing = clr_busy_q;
	assign result.valid    = res_v_q;
	assign result.data     = res_q;

endmodule

// ===== sv/weighted_2d_histogram_accumulate_top.sv =====
// Top level of the weighted 2D histogram accumulator.
//
//  channel  dir  payload                                              transfer
//  item     in   kind surface first_index second_index amp_re amp_im  valid & ready
//  result   out  bin_first bin_second density                         valid & ready
//  cfg      in   cfg_index cfg_data                                   cfg_we
//
// Sustains one item per cycle while no clearing pass runs and no read result
// stalls; a read result passes the front stage, the queue, the back-end stage
// and the result register. The rate is set by the bin memory read-modify-write
// in the back end, closed by one-deep forwarding of the previous write.
// After reset a clearing pass zeroes every bin of the memory with item.ready
// low; config writes are taken throughout.
// A stalled result holds the back end once the next read reaches it; the queue
// lets the front keep taking items until it fills.
module weighted_2d_histogram_accumulate_top #(
	parameter int INDEX_BITS = wh2h_pkg::DEF_INDEX_BITS,
	parameter int ACC_BITS   = wh2h_pkg::DEF_ACC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wh2h_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wh2h_pkg::CFG_DATA_W-1:0] cfg_data,
	wh2h_in_if.sink                         item,
	wh2h_out_if.source                      result
);
	import wh2h_pkg::*;

	// front -> queue
	logic   push_valid;
	logic   push_ready;
	entry_t push_data;

	// queue -> back
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	back_status_t status;

	// classifies items, drops non-matching samples, squares amplitudes
	wh2h_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.status     (status),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouples the two halves
	wh2h_fifo #(
		.DEPTH(DEF_QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// bin memory, saturating accumulate, read-and-clear
	wh2h_back #(
		.INDEX_BITS(INDEX_BITS),
		.ACC_BITS  (ACC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.status    (status),
		.result    (result)
	);

	// no item taken while the bin memory is being cleared
	a_no_item_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !item.ready
	) else $error("item ready during clearing pass");

	// nothing can reach the queue head before clearing ends
	a_queue_empty_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !pop_valid
	) else $error("queue holds work during clearing pass");

	// front stage keeps its entry until the queue takes it
	a_front_holds_on_full: assert property (
		@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (push_valid && $stable(push_data))
	) else $error("front stage lost a stalled entry");

endmodule

// ===== tb/tb.sv =====
// Testbench for the weighted 2D histogram block: directed and random items against a bin model.
`timescale 1ns / 100ps

module tb;
	import wh2h_pkg::*;

	// Timing knobs. The clearing pass after reset keeps item.ready low, and the
	// receiver hold-off lasts HOLD_CYCLES. The watchdog limit sits well above
	// both.
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 16;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          PHASE_ITEMS    = 230;
	localparam int          NUM_PHASES     = 6;
	localparam int          BIN_COUNT      = 1 << (2 * IDX_W);
	localparam logic [63:0] DENS_MAX       = (64'd1 << DENS_W) - 1;
	// back-to-back max-weight samples into one bin
	localparam int          BURST_ITEMS    = 40;

	// Bin model: mirrors the block's store and config, and queues the reads
	// whose results are still due.
	class density_tracker;
		logic [DENS_W-1:0] bin_sum [BIN_COUNT];
		logic              sel_surface;
		logic [IDX_W-1:0]  lim_first;
		logic [IDX_W-1:0]  lim_second;
		out_item_t         due_reads[$];
		int                errors;

		function new();
			foreach (bin_sum[i])
				bin_sum[i] = '0;
			sel_surface = 1'b0;
			lim_first   = LIMIT_RESET;
			lim_second  = LIMIT_RESET;
			errors      = 0;
		endfunction

		// Apply one accepted item to the model.
		function void note_item(in_item_t it);
			longint          re;
			longint          im;
			logic [63:0]     sum;
			logic [2*IDX_W-1:0] addr;
			out_item_t       r;
			addr = {it.first_index, it.second_index};
			if (it.kind == KIND_READ) begin
				// read and clear; limits and surface do not apply
				r.bin_first  = it.first_index;
				r.bin_second = it.second_index;
				r.density    = bin_sum[addr];
				due_reads    = {due_reads, r};
				bin_sum[addr] = '0;
				return;
			end
			if (it.surface != sel_surface)
				return;
			if (it.first_index > lim_first || it.second_index > lim_second)
				return;
			re  = it.amp_real;
			im  = it.amp_imag;
			sum = 64'(bin_sum[addr]) + 64'(re * re + im * im);
			bin_sum[addr] = (sum > DENS_MAX) ? DENS_MAX[DENS_W-1:0] : sum[DENS_W-1:0];
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		// Compare one accepted result with the oldest due read.
		task check_result(out_item_t got);
			out_item_t want;
			if (due_reads.size() == 0) begin
				report($sformatf("unexpected result bin (%0d,%0d) density %0h",
					got.bin_first, got.bin_second, got.density));
				return;
			end
			want = due_reads.pop_front();
			if (got.bin_first !== want.bin_first)
				report($sformatf("bin_first %0d, expected %0d", got.bin_first, want.bin_first));
			if (got.bin_second !== want.bin_second)
				report($sformatf("bin_second %0d, expected %0d",
					got.bin_second, want.bin_second));
			if (got.density !== want.density)
				report($sformatf("bin (%0d,%0d) density %0h, expected %0h",
					want.bin_first, want.bin_second, got.density, want.density));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wh2h_in_if  item_ch();
	wh2h_out_if result_ch();

	density_tracker tracker;
	bit             hold_req;   // main sequence asks the receiver for a long hold-off
	bit             rx_steady;  // receiver takes every result with no stalls
	int             quiet_cycles;

	weighted_2d_histogram_accumulate_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle stretch length: mostly none, some short, a few long.
	function automatic int idle_len(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Index biased toward the limit, the cell just past it and a few hot bins,
	// so reads find sums of several samples.
	function automatic logic [IDX_W-1:0] pick_index(logic [IDX_W-1:0] lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return lim;
		if (r < 25)
			return (lim == LIMIT_RESET) ? lim : lim + 1'b1;
		if (r < 65)
			return IDX_W'($urandom_range(0, (lim < 2) ? lim : 2));
		if (r < 90)
			return IDX_W'($urandom_range(0, lim));
		return IDX_W'($urandom_range(0, 15));
	endfunction

	function automatic logic signed [AMP_W-1:0] pick_amp();
		if ($urandom_range(0, 99) < 12) begin
			case ($urandom_range(0, 3))
				0:       return 16'h8000;
				1:       return 16'h7FFF;
				2:       return 16'h0000;
				default: return 16'hFFFF;
			endcase
		end
		return AMP_W'($urandom);
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.kind         = ($urandom_range(0, 99) < 25) ? KIND_READ : KIND_ACCUM;
		// mostly the selected surface, some mismatches
		it.surface      = ($urandom_range(0, 99) < 80) ? tracker.sel_surface
			: ~tracker.sel_surface;
		it.first_index  = pick_index(tracker.lim_first);
		it.second_index = pick_index(tracker.lim_second);
		it.amp_real     = pick_amp();
		it.amp_imag     = pick_amp();
		return it;
	endfunction

	// Offer one item after a random gap and hold it until the transfer.
	// Called at a rising edge; returns at the edge of the transfer.
	task automatic send(input in_item_t it, input bit steady);
		int gap;
		gap = idle_len(steady);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	task automatic acc(input logic surf, input logic [IDX_W-1:0] f, input logic [IDX_W-1:0] s,
			input logic signed [AMP_W-1:0] re, input logic signed [AMP_W-1:0] im);
		in_item_t it;
		it.kind         = KIND_ACCUM;
		it.surface      = surf;
		it.first_index  = f;
		it.second_index = s;
		it.amp_real     = re;
		it.amp_imag     = im;
		send(it, 1'b0);
	endtask

	// Read with junk in the fields the block ignores.
	task automatic rd(input logic [IDX_W-1:0] f, input logic [IDX_W-1:0] s);
		in_item_t it;
		it              = rand_item();
		it.kind         = KIND_READ;
		it.first_index  = f;
		it.second_index = s;
		send(it, 1'b0);
	endtask

	// Stop offering, wait for every due read, then let in-flight accumulates
	// (which give no result) drain through the back end.
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; block is idle.
	task automatic write_settings(input logic sel, input logic [IDX_W-1:0] l1,
			input logic [IDX_W-1:0] l2);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SELECTED_SURFACE;
		cfg_data  <= CFG_DATA_W'(sel);
		@(posedge clk);
		cfg_index <= CFG_FIRST_INDEX_LIMIT;
		cfg_data  <= CFG_DATA_W'(l1);
		@(posedge clk);
		cfg_index <= CFG_SECOND_INDEX_LIMIT;
		cfg_data  <= CFG_DATA_W'(l2);
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.sel_surface = sel;
		tracker.lim_first   = l1;
		tracker.lim_second  = l2;
	endtask

	// Transfer monitors: sample at the edge, before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				tracker.note_item(item_ch.data);
			if (result_ch.valid && result_ch.ready)
				tracker.check_result(result_ch.data);
		end
	end

	// Watchdog: ends the run after too many cycles with no transfer at all.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result receiver: random stalls, steady stretches, and one long hold-off
	// on request while the sender keeps offering reads, so the queue fills and
	// item.ready drops.
	initial begin
		int gap;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_steady) begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = idle_len(1'b0);
				if (gap > 0) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		in_item_t         it;
		int               n;
		int               p;
		logic             sel;
		logic [IDX_W-1:0] l1;
		logic [IDX_W-1:0] l2;

		tracker         = new();
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		hold_req        = 1'b0;
		rx_steady       = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset config (surface 0, limits 15). First items wait out
		// the clearing pass.
		acc(1'b0, 4'd0,  4'd0,  16'h0000, 16'h0000);  // zero weight
		acc(1'b0, 4'd15, 4'd15, 16'h8000, 16'h8000);  // largest weight, 2^31
		acc(1'b0, 4'd15, 4'd0,  16'h7FFF, 16'h8000);
		acc(1'b0, 4'd0,  4'd15, 16'hFFFF, 16'h0001);
		acc(1'b1, 4'd0,  4'd15, 16'h3039, 16'hFFFB);  // wrong surface, dropped
		rd(4'd15, 4'd15);
		rd(4'd15, 4'd15);                             // cleared by the read before
		rd(4'd15, 4'd0);
		rd(4'd0,  4'd15);
		rd(4'd0,  4'd0);
		rd(4'd9,  4'd6);                              // never written, zero from reset
		settle();

		// Narrow limits on surface 1: the cells just past each limit are
		// dropped, yet reads still reach them.
		write_settings(1'b1, 4'd3, 4'd5);
		acc(1'b1, 4'd3, 4'd5, 16'h0064, 16'hFF38);
		acc(1'b1, 4'd4, 4'd5, 16'h0007, 16'h0007);
		acc(1'b1, 4'd3, 4'd6, 16'h0007, 16'h0007);
		acc(1'b0, 4'd3, 4'd5, 16'h0007, 16'h0007);
		acc(1'b1, 4'd0, 4'd0, 16'h8000, 16'h7FFF);
		rd(4'd3, 4'd5);
		rd(4'd4, 4'd5);
		rd(4'd3, 4'd6);
		rd(4'd0, 4'd0);
		settle();

		// Limits at zero: only bin (0,0) counts.
		write_settings(1'b0, 4'd0, 4'd0);
		acc(1'b0, 4'd0, 4'd0, 16'h0001, 16'h0001);
		acc(1'b0, 4'd1, 4'd0, 16'h0001, 16'h0001);
		acc(1'b0, 4'd0, 4'd1, 16'h0001, 16'h0001);
		rd(4'd0,  4'd0);
		rd(4'd15, 4'd15);
		settle();

		// Back-to-back max-weight samples into one bin, then read the sum.
		write_settings(1'b0, 4'd15, 4'd15);
		it.kind         = KIND_ACCUM;
		it.surface      = 1'b0;
		it.first_index  = 4'd7;
		it.second_index = 4'd11;
		it.amp_real     = 16'h8000;
		it.amp_imag     = 16'h8000;
		for (n = 0; n < BURST_ITEMS; n++)
			send(it, 1'b1);
		rd(4'd7, 4'd11);

		// Random phases, one register setting each, extremes included.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin sel = 1'b0; l1 = 4'd15; l2 = 4'd15; end
				1: begin sel = 1'b1; l1 = 4'd15; l2 = 4'd15; end
				2: begin sel = 1'b0; l1 = 4'd0;  l2 = 4'd0;  end
				3: begin sel = 1'b1; l1 = 4'd7;  l2 = 4'd3;  end
				4: begin sel = 1'b0; l1 = 4'd15; l2 = 4'd0;  end
				default: begin
					sel = 1'($urandom_range(0, 1));
					l1  = IDX_W'($urandom_range(0, 15));
					l2  = IDX_W'($urandom_range(0, 15));
				end
			endcase
			settle();
			write_settings(sel, l1, l2);
			// phase 4 runs with no idling on either side
			rx_steady = (p == 4);
			if (p == 1) begin
				// back-pressure: receiver holds off while reads keep coming
				hold_req = 1'b1;
				for (n = 0; n < 30; n++) begin
					it      = rand_item();
					it.kind = KIND_READ;
					send(it, 1'b1);
				end
			end
			for (n = 0; n < PHASE_ITEMS; n++)
				send(rand_item(), p == 4);
		end
		rx_steady = 1'b0;
		settle();

		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
sv/wh2h_pkg.sv
sv/wh2h_in_if.sv
sv/wh2h_out_if.sv
sv/wh2h_front.sv
sv/wh2h_fifo.sv
sv/wh2h_back.sv
sv/weighted_2d_histogram_accumulate_top.sv
tb/tb.sv
